### design/gedge_pkg.sv
// Shared types, codes and mask coefficients of the gradient edge detector.
package gedge_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_KIND      = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd3;

    // Mask kinds.
    localparam logic [1:0] KIND_ROBERTS = 2'd0;
    localparam logic [1:0] KIND_SOBEL   = 2'd1;
    localparam logic [1:0] KIND_PREWITT = 2'd2;
    localparam logic [1:0] KIND_STOCH   = 2'd3;

    // Request types.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_MASK   = 5;
    localparam int QUEUE_DEPTH    = 2;
    localparam int STOCH_SCALE    = 1000;

    localparam logic [7:0] EDGE_ON  = 8'd255;
    localparam logic [7:0] EDGE_OFF = 8'd0;

    typedef struct packed {
        logic [10:0] w;
        logic [10:0] h;
        logic [1:0]  kind;
        logic [11:0] thr;
    } t_cfg;

    typedef struct packed {
        logic [10:0] n;
        logic [10:0] m;
        logic [10:0] w;
        logic [10:0] h;
        logic [1:0]  kind;
        logic [11:0] thr;
        logic        last;
    } t_job;

    // All masks on a 5x5 grid, the 3x3 masks in its center: [kind][x/y][row][col].
    localparam logic signed [10:0] COEF [4][2][5][5] = '{
        '{ '{ '{0,0,0,0,0}, '{0,0,0,-1,0}, '{0,0,1,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0} },
           '{ '{0,0,0,0,0}, '{0,-1,0,0,0}, '{0,0,1,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0} } },
        '{ '{ '{0,0,0,0,0}, '{0,1,0,-1,0}, '{0,2,0,-2,0}, '{0,1,0,-1,0}, '{0,0,0,0,0} },
           '{ '{0,0,0,0,0}, '{0,-1,-2,-1,0}, '{0,0,0,0,0}, '{0,1,2,1,0}, '{0,0,0,0,0} } },
        '{ '{ '{0,0,0,0,0}, '{0,1,0,-1,0}, '{0,1,0,-1,0}, '{0,1,0,-1,0}, '{0,0,0,0,0} },
           '{ '{0,0,0,0,0}, '{0,-1,-1,-1,0}, '{0,0,0,0,0}, '{0,1,1,1,0}, '{0,0,0,0,0} } },
        '{ '{ '{267,364,0,-364,-267}, '{373,562,0,-562,-373},
              '{463,1000,0,-1000,-463}, '{373,562,0,-562,-373},
              '{267,364,0,-364,-267} },
           '{ '{267,373,463,373,267}, '{364,562,1000,562,364}, '{0,0,0,0,0},
              '{-267,-373,-463,-373,-267}, '{-364,-562,-1000,-562,-364} } }
    };

    function automatic logic signed [10:0] gedge_coef(input logic [1:0] kind,
                                                      input logic axis,
                                                      input logic [2:0] row,
                                                      input logic [2:0] col);
        return COEF[kind][axis][row][col];
    endfunction

endpackage

### design/gedge_if.sv
// Stream interfaces for pixel requests and edge results.
interface gedge_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] pixel_in;
    modport source(output valid, output req_type, output pixel_in, input ready);
    modport sink(input valid, input req_type, input pixel_in, output ready);
endinterface

interface gedge_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_pixel;
    logic       frame_last;
    modport source(output valid, output edge_pixel, output frame_last, input ready);
    modport sink(input valid, input edge_pixel, input frame_last, output ready);
endinterface

### design/gedge_fifo.sv
// Short job queue between the front and the back of the edge detector.
module gedge_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [IW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [IW-1:0] bump(input logic [IW-1:0] p);
        return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= bump(r_wp);
            end
            if (i_pop) begin
                r_rp <= bump(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

### design/gedge_front.sv
// Front end: accepts items, writes the line store and decides when a result is due.
module gedge_front #(
    parameter int MAX_WIDTH = gedge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_MASK  = gedge_pkg::DEF_MAX_MASK,
    parameter int PW        = $clog2((MAX_MASK + 1) * MAX_WIDTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gedge_in_if.sink        i_in,
    input  gedge_pkg::t_cfg i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output gedge_pkg::t_job o_job,
    output logic [PW-1:0]   o_base,
    output logic            o_wr_en,
    output logic [PW-1:0]   o_wr_addr,
    output logic [7:0]      o_wr_data
);
    import gedge_pkg::*;

    localparam int RING = (MAX_MASK + 1) * MAX_WIDTH;
    localparam int CW   = $clog2(RING + 1);
    localparam int NW   = (CW > 13) ? CW : 13;

    logic [CW-1:0] r_pend, n_pend, pend1;
    logic [PW-1:0] r_wr, r_base;
    logic [10:0]   r_n, r_m;
    logic          acc, is_pix, emit, rad2, last;
    logic [10:0]   hm1, wm1, n_eff, row_room, col_room;
    logic [1:0]    k, j;
    logic [12:0]   kw, need;

    always_comb begin
        is_pix   = (i_in.req_type == REQ_PIXEL);
        acc      = i_in.valid && i_in.ready;
        pend1    = (is_pix && r_pend < CW'(RING)) ? r_pend + CW'(1) : r_pend;
        hm1      = i_cfg.h - 11'd1;
        wm1      = i_cfg.w - 11'd1;
        n_eff    = (r_n > hm1) ? hm1 : r_n;
        row_room = hm1 - n_eff;
        col_room = wm1 - r_m;
        rad2     = (i_cfg.kind == KIND_STOCH);
        if (rad2) begin
            k = (row_room >= 11'd2) ? 2'd2 : row_room[1:0];
            j = (col_room >= 11'd2) ? 2'd2 : col_room[1:0];
        end else begin
            k = (row_room >= 11'd1) ? 2'd1 : 2'd0;
            j = (col_room >= 11'd1) ? 2'd1 : 2'd0;
        end
        // Distance from this position to the newest pixel its window needs.
        if (k == 2'd2) begin
            kw = {1'b0, i_cfg.w, 1'b0};
        end else if (k == 2'd1) begin
            kw = {2'b00, i_cfg.w};
        end else begin
            kw = '0;
        end
        need = kw + {11'd0, j};
        emit = acc && (pend1 != '0) && (NW'(pend1) > NW'(need));
        last = (n_eff == hm1) && (r_m == wm1);
        n_pend = emit ? pend1 - CW'(1) : pend1;
    end

    assign i_in.ready = !i_full;
    assign o_push     = emit;
    assign o_base     = r_base;
    assign o_wr_en    = acc && is_pix;
    assign o_wr_addr  = r_wr;
    assign o_wr_data  = i_in.pixel_in;

    always_comb begin
        o_job.n    = n_eff;
        o_job.m    = r_m;
        o_job.w    = i_cfg.w;
        o_job.h    = i_cfg.h;
        o_job.kind = i_cfg.kind;
        o_job.thr  = i_cfg.thr;
        o_job.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_wr   <= '0;
            r_base <= '0;
            r_n    <= '0;
            r_m    <= '0;
        end else if (acc) begin
            r_pend <= n_pend;
            if (is_pix) begin
                r_wr <= (r_wr == PW'(RING - 1)) ? '0 : r_wr + PW'(1);
            end
            if (emit) begin
                r_base <= (r_base == PW'(RING - 1)) ? '0 : r_base + PW'(1);
                if (last) begin
                    r_n <= '0;
                    r_m <= '0;
                end else if (r_m == wm1) begin
                    r_n <= n_eff + 11'd1;
                    r_m <= '0;
                end else begin
                    r_n <= n_eff;
                    r_m <= r_m + 11'd1;
                end
            end
        end
    end
endmodule

### design/gedge_back.sv
// Back end: walks the window through the line store, accumulates and thresholds.
module gedge_back #(
    parameter int MAX_WIDTH = gedge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_MASK  = gedge_pkg::DEF_MAX_MASK,
    parameter int PW        = $clog2((MAX_MASK + 1) * MAX_WIDTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gedge_pkg::t_job i_job,
    input  logic [PW-1:0]   i_base,
    output logic            o_pop,
    input  logic            i_wr_en,
    input  logic [PW-1:0]   i_wr_addr,
    input  logic [7:0]      i_wr_data,
    gedge_out_if.source     o_out
);
    import gedge_pkg::*;

    localparam int RING = (MAX_MASK + 1) * MAX_WIDTH;
    localparam int AW   = PW + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAP   = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;

    logic [7:0]          r_mem [RING];
    logic [2:0]          r_state;
    t_job                r_job;
    logic [PW-1:0]       r_base;
    logic [2:0]          r_i, r_j;
    logic                r_v1;
    logic [7:0]          r_pix;
    logic signed [10:0]  r_cx, r_cy;
    logic signed [23:0]  r_gx, r_gy;
    logic [21:0]         r_thr_s;
    logic [47:0]         r_sqx, r_sqy;
    logic [43:0]         r_thrsq;
    logic                r_ov;
    logic [7:0]          r_edge;
    logic                r_last;

    logic [2:0]          rad, span, grow, gcol;
    logic signed [3:0]   dr, dc;
    logic signed [12:0]  ir, ic, roff, coff;
    logic signed [13:0]  w14, rowd;
    logic signed [AW-1:0] addr_s;
    logic [PW-1:0]       addr;
    logic                tap_last;
    logic signed [19:0]  prod_x, prod_y;
    logic [48:0]         mag;

    always_comb begin
        rad  = (r_job.kind == KIND_STOCH) ? 3'd2 : 3'd1;
        span = {rad[1:0], 1'b0};
        grow = r_i + (3'd2 - rad);
        gcol = r_j + (3'd2 - rad);
        dr   = $signed({1'b0, r_i}) - $signed({1'b0, rad});
        dc   = $signed({1'b0, r_j}) - $signed({1'b0, rad});
        ir   = $signed({2'b00, r_job.n}) + 13'(dr);
        ic   = $signed({2'b00, r_job.m}) + 13'(dc);
        // Clamp window coordinates to the frame.
        if (ir < 0) begin
            ir = '0;
        end else if (ir > $signed({2'b00, r_job.h - 11'd1})) begin
            ir = $signed({2'b00, r_job.h - 11'd1});
        end
        if (ic < 0) begin
            ic = '0;
        end else if (ic > $signed({2'b00, r_job.w - 11'd1})) begin
            ic = $signed({2'b00, r_job.w - 11'd1});
        end
        roff = ir - $signed({2'b00, r_job.n});
        coff = ic - $signed({2'b00, r_job.m});
        w14  = $signed({3'b000, r_job.w});
        if (roff == -13'sd2) begin
            rowd = -(w14 <<< 1);
        end else if (roff == -13'sd1) begin
            rowd = -w14;
        end else if (roff == 13'sd1) begin
            rowd = w14;
        end else if (roff == 13'sd2) begin
            rowd = w14 <<< 1;
        end else begin
            rowd = '0;
        end
        addr_s = $signed({2'b00, r_base}) + AW'(rowd) + AW'(coff);
        if (addr_s < 0) begin
            addr_s = addr_s + AW'(RING);
        end else if (addr_s >= AW'(RING)) begin
            addr_s = addr_s - AW'(RING);
        end
        addr     = addr_s[PW-1:0];
        tap_last = (r_i == span) && (r_j == span);
        prod_x   = r_cx * $signed({1'b0, r_pix});
        prod_y   = r_cy * $signed({1'b0, r_pix});
        mag      = {1'b0, r_sqx} + {1'b0, r_sqy};
    end

    assign o_pop            = (r_state == S_IDLE) && i_valid;
    assign o_out.valid      = r_ov;
    assign o_out.edge_pixel = r_edge;
    assign o_out.frame_last = r_last;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_pix <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_ov    <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_gx    <= '0;
            r_gy    <= '0;
        end else begin
            r_v1 <= (r_state == S_TAP);
            if (r_v1) begin
                r_gx <= r_gx + 24'(prod_x);
                r_gy <= r_gy + 24'(prod_y);
            end
            if (o_out.valid && o_out.ready && (r_state != S_CMP)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_gx    <= '0;
                        r_gy    <= '0;
                        r_state <= S_TAP;
                    end
                end
                S_TAP: begin
                    if (tap_last) begin
                        r_state <= S_FLUSH;
                    end else if (r_j == span) begin
                        r_j <= '0;
                        r_i <= r_i + 3'd1;
                    end else begin
                        r_j <= r_j + 3'd1;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cx <= gedge_coef(r_job.kind, 1'b0, grow, gcol);
        r_cy <= gedge_coef(r_job.kind, 1'b1, grow, gcol);
        if (o_pop) begin
            r_job   <= i_job;
            r_base  <= i_base;
            r_thr_s <= (i_job.kind == KIND_STOCH) ? 22'(i_job.thr) * 22'(STOCH_SCALE)
                                                  : 22'(i_job.thr);
        end
        if (r_state == S_SQ) begin
            r_sqx   <= 48'(r_gx * r_gx);
            r_sqy   <= 48'(r_gy * r_gy);
            r_thrsq <= 44'(r_thr_s) * 44'(r_thr_s);
        end
        if (r_state == S_CMP && (!r_ov || o_out.ready)) begin
            r_edge <= (mag > 49'(r_thrsq)) ? EDGE_ON : EDGE_OFF;
            r_last <= r_job.last;
        end
    end

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (r_i <= span && r_j <= span))
        else $error("window tap counter out of range");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (addr_s >= 0 && addr_s < AW'(RING)))
        else $error("line store address outside the ring");

    a_acc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> !r_v1)
        else $error("accumulation still running when squaring starts");
endmodule

### design/gradient_edge_threshold_top.sv
// Top level of the streaming gradient edge detector with threshold.
//
//  channel   direction  handshake      payload
//  i_in      in         valid/ready    req_type, pixel_in
//  o_out     out        valid/ready    edge_pixel, frame_last
//  i_cfg_*   in         i_cfg_we only  i_cfg_idx, i_cfg_data
//
// Items are accepted one per cycle while the job queue has room. Each result
// comes from a walk over its 3x3 or 5x5 window through the single read port
// of the line store, one tap a cycle, with a step each to start, finish the
// last tap, square the gradients and compare with the squared threshold.
// Reset is synchronous and active low; the line store is not cleared, since
// every entry is written before it is read. The output register lets the
// back end finish a result while the sink stalls, and the queue lets the
// front keep taking items while the back end works.
module gradient_edge_threshold_top #(
    parameter int MAX_WIDTH  = gedge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gedge_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_MASK   = gedge_pkg::DEF_MAX_MASK
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gedge_in_if.sink    i_in,
    gedge_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data
);
    import gedge_pkg::*;

    localparam int PW = $clog2((MAX_MASK + 1) * MAX_WIDTH);
    localparam int JW = $bits(t_job) + PW;

    logic [10:0] r_fw, r_fh;
    logic [1:0]  r_kind;
    logic [11:0] r_thr;
    t_cfg        cfg;

    logic          push, full, pop, qvalid;
    t_job          f_job, b_job;
    logic [PW-1:0] f_base, b_base;
    logic [JW-1:0] q_out;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= 11'd1024;
            r_fh   <= 11'd1024;
            r_kind <= KIND_SOBEL;
            r_thr  <= 12'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:     r_fw   <= i_cfg_data[10:0];
                CFG_HEIGHT:    r_fh   <= i_cfg_data[10:0];
                CFG_KIND:      r_kind <= i_cfg_data[1:0];
                CFG_THRESHOLD: r_thr  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective sizes: zero acts as one, anything above the build maximum
    // acts as the maximum. A build without the 5x5 mask treats it as Sobel.
    always_comb begin
        if (r_fw == '0) begin
            cfg.w = 11'd1;
        end else if ({2'b00, r_fw} > 13'(MAX_WIDTH)) begin
            cfg.w = 11'(MAX_WIDTH);
        end else begin
            cfg.w = r_fw;
        end
        if (r_fh == '0) begin
            cfg.h = 11'd1;
        end else if ({2'b00, r_fh} > 13'(MAX_HEIGHT)) begin
            cfg.h = 11'(MAX_HEIGHT);
        end else begin
            cfg.h = r_fh;
        end
        cfg.kind = (r_kind == KIND_STOCH && MAX_MASK < 5) ? KIND_SOBEL : r_kind;
        cfg.thr  = r_thr;
    end

    gedge_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_MASK  (MAX_MASK),
        .PW        (PW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (cfg),
        .i_full    (full),
        .o_push    (push),
        .o_job     (f_job),
        .o_base    (f_base),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    gedge_fifo #(
        .DW    (JW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_base, f_job}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_data  (q_out)
    );

    assign b_job  = q_out[$bits(t_job)-1:0];
    assign b_base = q_out[JW-1:$bits(t_job)];

    gedge_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_MASK  (MAX_MASK),
        .PW        (PW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (qvalid),
        .i_job     (b_job),
        .i_base    (b_base),
        .o_pop     (pop),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_out     (o_out)
    );
endmodule

### tb/testbench.sv
// Self-checking testbench for the streaming gradient edge detector with threshold.
`timescale 1ns / 1ps

module testbench;
    import gedge_pkg::*;

    localparam int RING_LEN   = 6 * 1024;
    localparam int STALL_MAX  = 5000;
    localparam int SETTLE_CYC = 100;
    localparam int HOLD_CYC   = 400;

    // Directed table operations.
    typedef enum logic [1:0] {OP_CONFIG, OP_PIXEL, OP_DRAIN, OP_FLUSH} t_op;

    typedef struct {
        t_op        op;
        int         w, h, kind, thr;
        logic [7:0] pix;
        bit         typed;
        logic [7:0] edge_px;
        logic       last;
    } t_row;

    typedef struct {
        logic [7:0] edge_px;
        logic       last;
    } t_edge_result;

    logic clk;
    logic rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [11:0] cfg_data;

    gedge_in_if  in_if();
    gedge_out_if out_if();

    gradient_edge_threshold_top DUT (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // Mask coefficients on a 5x5 grid: [kind][x/y][row][col]. The stochastic
    // mask is held in thousandths.
    localparam int MASK [4][2][5][5] = '{
        '{ '{ '{0,0,0,0,0}, '{0,0,0,-1,0}, '{0,0,1,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0} },
           '{ '{0,0,0,0,0}, '{0,-1,0,0,0}, '{0,0,1,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0} } },
        '{ '{ '{0,0,0,0,0}, '{0,1,0,-1,0}, '{0,2,0,-2,0}, '{0,1,0,-1,0}, '{0,0,0,0,0} },
           '{ '{0,0,0,0,0}, '{0,-1,-2,-1,0}, '{0,0,0,0,0}, '{0,1,2,1,0}, '{0,0,0,0,0} } },
        '{ '{ '{0,0,0,0,0}, '{0,1,0,-1,0}, '{0,1,0,-1,0}, '{0,1,0,-1,0}, '{0,0,0,0,0} },
           '{ '{0,0,0,0,0}, '{0,-1,-1,-1,0}, '{0,0,0,0,0}, '{0,1,1,1,0}, '{0,0,0,0,0} } },
        '{ '{ '{267,364,0,-364,-267}, '{373,562,0,-562,-373},
              '{463,1000,0,-1000,-463}, '{373,562,0,-562,-373},
              '{267,364,0,-364,-267} },
           '{ '{267,373,463,373,267}, '{364,562,1000,562,364}, '{0,0,0,0,0},
              '{-267,-373,-463,-373,-267}, '{-364,-562,-1000,-562,-364} } }
    };

    // Predictor state: its own copy of the registers, the pixel ring, the
    // count of pixels not yet answered and the raster position of the next
    // result.
    logic [10:0] reg_w, reg_h;
    logic [1:0]  reg_kind;
    logic [11:0] reg_thr;
    logic [7:0]  pix_ring [RING_LEN];
    int          ring_wr;
    int          unanswered;
    int          next_pos;

    t_edge_result expected_edges[$];
    int  mismatches;
    int  stall_cycles;
    int  items_sent;
    bit  quiet;
    bit  hold_out;

    // The sender takes no pause and the receiver never stalls while quiet is
    // set, so the block also sees long unbroken runs.
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int clamp_dim(logic [10:0] v);
        if (v == 0) return 1;
        return (v > 1024) ? 1024 : int'(v);
    endfunction

    // Works out the result, if any, that the accepted item releases.
    function automatic bit edge_predict(logic req, logic [7:0] pix,
                                        output t_edge_result res);
        int w, h, r, n, m, pos, lr, lc, lastpos, base, ir, ic, loc;
        longint gx, gy, thr, px;
        w = clamp_dim(reg_w);
        h = clamp_dim(reg_h);
        r = (reg_kind == KIND_STOCH) ? 2 : 1;
        if (req == REQ_PIXEL) begin
            pix_ring[ring_wr] = pix;
            ring_wr = (ring_wr + 1) % RING_LEN;
            if (unanswered < RING_LEN) unanswered++;
        end
        if (unanswered == 0) return 0;
        n = next_pos / w;
        m = next_pos % w;
        if (n > h - 1) n = h - 1;
        pos = n * w + m;
        lr = (n + r > h - 1) ? h - 1 : n + r;
        lc = (m + r > w - 1) ? w - 1 : m + r;
        lastpos = lr * w + lc;
        if (pos + unanswered <= lastpos) return 0;
        base = (ring_wr + RING_LEN - (unanswered % RING_LEN)) % RING_LEN;
        gx = 0;
        gy = 0;
        for (int dr = -r; dr <= r; dr++) begin
            for (int dc = -r; dc <= r; dc++) begin
                // Window taps outside the frame take the nearest edge pixel.
                ir = n + dr;
                ic = m + dc;
                if (ir < 0) ir = 0;
                if (ir > h - 1) ir = h - 1;
                if (ic < 0) ic = 0;
                if (ic > w - 1) ic = w - 1;
                loc = (base + ir * w + ic - pos) % RING_LEN;
                if (loc < 0) loc += RING_LEN;
                px = pix_ring[loc];
                gx += MASK[reg_kind][0][2 + dr][2 + dc] * px;
                gy += MASK[reg_kind][1][2 + dr][2 + dc] * px;
            end
        end
        thr = longint'(reg_thr) * ((reg_kind == KIND_STOCH) ? STOCH_SCALE : 1);
        res.edge_px = (gx * gx + gy * gy > thr * thr) ? EDGE_ON : EDGE_OFF;
        res.last = (pos == w * h - 1);
        unanswered--;
        next_pos = (pos + 1 >= w * h) ? 0 : pos + 1;
        return 1;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Writes all four registers in consecutive cycles; the block is idle.
    task automatic configure(int w, int h, int kind, int thr);
        logic [11:0] vals [4];
        vals = '{w[11:0], h[11:0], kind[11:0], thr[11:0]};
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= i[1:0];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        reg_w    = vals[CFG_WIDTH][10:0];
        reg_h    = vals[CFG_HEIGHT][10:0];
        reg_kind = vals[CFG_KIND][1:0];
        reg_thr  = vals[CFG_THRESHOLD];
    endtask

    // Offers one item, waits for it to be taken and files the expectation.
    task automatic send_item(logic req, logic [7:0] pix, bit typed = 0,
                             t_edge_result typed_res = '{8'd0, 1'b0});
        t_edge_result res;
        bit produced;
        if (!quiet && $urandom_range(99) < 10) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.req_type <= req;
        in_if.pixel_in <= pix;
        do @(posedge clk); while (!in_if.ready);
        produced = edge_predict(req, pix, res);
        if (produced) expected_edges.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Drain ticks release the last rows of the frame.
    task automatic flush_frame();
        while (unanswered != 0) send_item(REQ_DRAIN, 8'($urandom));
        wait_idle();
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic stream_frame(int frac_drain);
        int total;
        total = clamp_dim(reg_w) * clamp_dim(reg_h);
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(99) < frac_drain) send_item(REQ_DRAIN, pick_pixel());
            send_item(REQ_PIXEL, pick_pixel());
        end
    endtask

    // Directed part. A 1x1 frame has a flat window, so its gradient is zero
    // and no threshold is exceeded, and each result is the last of its frame.
    t_row directed [] = '{
        '{OP_CONFIG, 1, 1, 1, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd0, 1, EDGE_OFF, 1'b1},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd255, 1, EDGE_OFF, 1'b1},
        '{OP_DRAIN, 0, 0, 0, 0, 8'd77, 0, 8'd0, 1'b0},
        '{OP_FLUSH, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_CONFIG, 3, 2, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd255, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd255, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd255, 0, 8'd0, 1'b0},
        '{OP_FLUSH, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_CONFIG, 2, 2, 3, 4095, 8'd0, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd255, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd255, 0, 8'd0, 1'b0},
        '{OP_FLUSH, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_CONFIG, 2, 2, 2, 1, 8'd0, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd255, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd255, 0, 8'd0, 1'b0},
        '{OP_PIXEL, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0},
        '{OP_FLUSH, 0, 0, 0, 0, 8'd0, 0, 8'd0, 1'b0}
    };

    // Stimulus: reset, the directed table, then random phases of whole
    // frames, each closed by drain ticks so that the block is idle before
    // the next register writes.
    initial begin
        int phase;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_WIDTH;
        cfg_data       <= 12'd0;
        in_if.valid    <= 1'b0;
        in_if.req_type <= REQ_PIXEL;
        in_if.pixel_in <= 8'd0;
        mismatches = 0;
        items_sent = 0;
        quiet      = 0;
        hold_out   = 0;
        reg_w = 11'd1024;
        reg_h = 11'd1024;
        reg_kind = KIND_SOBEL;
        reg_thr = 12'd50;
        ring_wr = 0;
        unanswered = 0;
        next_pos = 0;
        foreach (pix_ring[i]) pix_ring[i] = 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            case (directed[i].op)
                OP_CONFIG: configure(directed[i].w, directed[i].h,
                                     directed[i].kind, directed[i].thr);
                OP_PIXEL:  send_item(REQ_PIXEL, directed[i].pix, directed[i].typed,
                                     '{directed[i].edge_px, directed[i].last});
                OP_DRAIN:  send_item(REQ_DRAIN, directed[i].pix);
                default:   flush_frame();
            endcase
        end

        phase = 0;
        while (items_sent < 950) begin
            int thr;
            case ($urandom_range(3))
                0: thr = 0;
                1: thr = 4095;
                2: thr = $urandom_range(0, 300);
                default: thr = $urandom_range(0, 4095);
            endcase
            configure((phase == 1) ? 12 :
                      (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12)),
                      (phase == 1) ? 10 :
                      (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10)),
                      $urandom_range(0, 3), thr);
            quiet = (phase >= 2 && phase < 5);
            // Hold the receiver off for a long time so the block fills up.
            if (phase == 1) hold_out = 1;
            repeat ($urandom_range(1, 3)) stream_frame(5);
            flush_frame();
            phase++;
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result receiver: random stalls, none while quiet, and one long hold-off
    // counted here.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_out) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                hold_out = 0;
            end else begin
                out_if.ready <= quiet || ($urandom_range(99) >= 10);
            end
        end
    end

    // Result checker and watchdog.
    always @(posedge clk) begin
        t_edge_result want;
        if (!rst_n) begin
            stall_cycles <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_edges.size() == 0) begin
                    report_mismatch($sformatf("unexpected result edge=%0d last=%0b",
                                              out_if.edge_pixel, out_if.frame_last));
                end else begin
                    want = expected_edges.pop_front();
                    if (out_if.edge_pixel !== want.edge_px)
                        report_mismatch($sformatf("edge_pixel %0d, expected %0d",
                                                  out_if.edge_pixel, want.edge_px));
                    if (out_if.frame_last !== want.last)
                        report_mismatch($sformatf("frame_last %0b, expected %0b",
                                                  out_if.frame_last, want.last));
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_MAX) begin
                $display("Mismatches found");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule

### files.f
design/gedge_pkg.sv
design/gedge_if.sv
design/gedge_fifo.sv
design/gedge_front.sv
design/gedge_back.sv
design/gradient_edge_threshold_top.sv
tb/testbench.sv
